// ===== rtl/crcc_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-32C stream checksum: shared package
// Constants, lane control type and elaboration-time functions that build
// the per-lane XOR columns of the reflected Castagnoli CRC.
// ----------------------------------------------------------------------------
package crcc_pkg;

  localparam int          CRCC_BEAT_BYTES_MAX = 16;
  localparam int          CRCC_BYTES_PER_BEAT = 16;
  localparam logic [31:0] CRCC_ALL_ONES       = 32'hffff_ffff;
  localparam logic [31:0] CRCC_POLY_REFL      = 32'h82f6_3b78;

  typedef struct packed {
    logic [7:0] data;
    logic       inject;
    logic [1:0] sel;
  } crcc_lane_ctl_t;

  function automatic logic [31:0] crcc_tab(input logic [7:0] b);
    logic [31:0] v;
    v = {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRCC_POLY_REFL) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [31:0] crcc_col(input int shift, input int bitpos);
    logic [31:0] v;
    v = crcc_tab(8'(1 << bitpos));
    for (int s = 0; s < shift; s++) begin
      v = crcc_tab(v[7:0]) ^ (v >> 8);
    end
    return v;
  endfunction

endpackage

// ===== rtl/crc32c_stream_checksum.sv =====
// An accepted beat is registered in s1; a last beat then registers its checksum
// with out_valid. Throughput: one beat per cycle unless in_stall; the running
// CRC feeds back through the lane XOR networks and merge combinationally.
// Reset clears both pipeline valids and seeds the running CRC with all ones.
// ----------------------------------------------------------------------------
// CRC-32C stream checksum: top level
// Align stage, parallel byte lanes, merge into the running CRC and an
// output register with stall.
// ----------------------------------------------------------------------------
module crc32c_stream_checksum
  import crcc_pkg::*;
#(
  parameter int BYTES_PER_BEAT = CRCC_BYTES_PER_BEAT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_low,
  input  logic [63:0] data_high,
  input  logic [4:0]  byte_count,
  input  logic        first_beat,
  input  logic        last_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] checksum
);

  localparam int N = BYTES_PER_BEAT;

  crcc_lane_ctl_t a_lanes [N];
  logic           a_short;
  logic [1:0]     a_shift;

  crcc_lane_ctl_t s1_lanes [N];
  logic           s1_valid;
  logic           s1_short;
  logic [1:0]     s1_shift;
  logic           s1_first;
  logic           s1_last;

  logic [31:0]    running_crc;
  logic [31:0]    crc_seed;
  logic [7:0]     seed_bytes [4];
  logic [7:0]     din [N];
  logic [31:0]    contrib [N];
  logic [31:0]    crc_next;
  logic           out_free;
  logic           fire;
  logic           take_in;

  crcc_align #(
    .BYTES_PER_BEAT(N)
  ) u_align (
    .data_low  (data_low),
    .data_high (data_high),
    .byte_count(byte_count),
    .lanes     (a_lanes),
    .short_tail(a_short),
    .tail_shift(a_shift)
  );

  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !fire;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take_in || (s1_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_lanes <= a_lanes;
      s1_short <= a_short;
      s1_shift <= a_shift;
      s1_first <= first_beat;
      s1_last  <= last_beat;
    end
  end

  assign crc_seed = s1_first ? CRCC_ALL_ONES : running_crc;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      seed_bytes[j] = crc_seed[8*j +: 8];
    end
  end

  for (genvar p = 0; p < N; p++) begin : g_lane
    assign din[p] = s1_lanes[p].data
                    ^ (s1_lanes[p].inject ? seed_bytes[s1_lanes[p].sel] : 8'h00);
    crcc_lane #(
      .SHIFT(N - 1 - p)
    ) u_lane (
      .din    (din[p]),
      .contrib(contrib[p])
    );
  end

  always_comb begin
    crc_next = s1_short ? (crc_seed >> {s1_shift, 3'b000}) : 32'h0;
    for (int p = 0; p < N; p++) begin
      crc_next = crc_next ^ contrib[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRCC_ALL_ONES;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        running_crc <= s1_last ? CRCC_ALL_ONES : crc_next;
      end
      if (fire && s1_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) begin
      checksum <= crc_next ^ CRCC_ALL_ONES;
    end
  end

endmodule

// ===== rtl/crcc_align.sv =====
// ----------------------------------------------------------------------------
// CRC-32C stream checksum: beat alignment
// Right-justifies the valid bytes of a beat onto the lanes and marks the
// lanes that take a byte of the incoming CRC.
// ----------------------------------------------------------------------------
module crcc_align
  import crcc_pkg::*;
#(
  parameter int BYTES_PER_BEAT = CRCC_BYTES_PER_BEAT
) (
  input  logic [63:0]    data_low,
  input  logic [63:0]    data_high,
  input  logic [4:0]     byte_count,
  output crcc_lane_ctl_t lanes [BYTES_PER_BEAT],
  output logic           short_tail,
  output logic [1:0]     tail_shift
);

  localparam int CW = $clog2(BYTES_PER_BEAT + 1);

  logic [7:0]    beat_bytes [CRCC_BEAT_BYTES_MAX];
  logic [CW-1:0] n;

  always_comb begin
    for (int i = 0; i < CRCC_BEAT_BYTES_MAX / 2; i++) begin
      beat_bytes[i]                           = data_low[8*i +: 8];
      beat_bytes[i + CRCC_BEAT_BYTES_MAX / 2] = data_high[8*i +: 8];
    end
  end

  assign n = (int'(byte_count) > BYTES_PER_BEAT) ? CW'(BYTES_PER_BEAT) : CW'(byte_count);
  assign short_tail = int'(n) < 4;
  assign tail_shift = 2'(n);

  always_comb begin
    int k;
    for (int p = 0; p < BYTES_PER_BEAT; p++) begin
      k = p + int'(n) - BYTES_PER_BEAT;
      lanes[p].data   = (k >= 0) ? beat_bytes[4'(k)] : 8'h00;
      lanes[p].inject = (k >= 0) && (k < 4);
      lanes[p].sel    = 2'(k);
    end
  end

endmodule

// ===== rtl/crcc_lane.sv =====
// ----------------------------------------------------------------------------
// CRC-32C stream checksum: byte lane
// XOR network giving one byte's contribution to the CRC after SHIFT more
// byte steps.
// ----------------------------------------------------------------------------
module crcc_lane
  import crcc_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic [7:0]  din,
  output logic [31:0] contrib
);

  logic [31:0] term [8];

  for (genvar b = 0; b < 8; b++) begin : g_bit
    localparam logic [31:0] COL = crcc_col(SHIFT, b);
    assign term[b] = din[b] ? COL : 32'h0;
  end

  always_comb begin
    contrib = 32'h0;
    for (int b = 0; b < 8; b++) begin
      contrib = contrib ^ term[b];
    end
  end

endmodule

// ===== rtl/crcc_checker.sv =====
// ----------------------------------------------------------------------------
// CRC-32C stream checksum: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module crcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] checksum
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(checksum))
    else $error("checksum dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side can drain");

endmodule

bind crc32c_stream_checksum crcc_checker u_crcc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .checksum (checksum)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// CRC-32C stream checksum testbench
// Drives beats of packet data through the block and checks each final
// checksum. A short table of directed beats comes first, with published
// CRC-32C check values typed in where they are known. Random messages of one
// to five beats follow, mixed with stray flags, odd byte counts and random
// idle bursts on both channels. Each checksum is compared in order against the
// typed-in value or else a bit-serial model of the reflected Castagnoli CRC.
// ----------------------------------------------------------------------------
module tb_top
  import crcc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  cnt;
    logic        first;
    logic        last;
    logic        known;
    logic [31:0] sum;
  } beat_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [63:0] data_low   = '0;
  logic [63:0] data_high  = '0;
  logic [4:0]  byte_count = '0;
  logic        first_beat = 1'b0;
  logic        last_beat  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] checksum;

  logic [31:0] crc_state = CRCC_ALL_ONES;
  logic [31:0] checksum_q[$];
  logic [31:0] want_sum;
  beat_t       directed_q[$];
  bit          quiet = 1'b0;
  int          mismatch_count = 0;
  int          beat_count = 0;
  int          sum_count = 0;

  crc32c_stream_checksum i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_low   (data_low),
    .data_high  (data_high),
    .byte_count (byte_count),
    .first_beat (first_beat),
    .last_beat  (last_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .checksum   (checksum)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] crc_fold_beat(input logic [31:0] crc,
                                                input logic [63:0] lo,
                                                input logic [63:0] hi,
                                                input logic [4:0] cnt);
    logic [127:0] bytes;
    int           n;
    bytes = {hi, lo};
    n = (cnt > CRCC_BYTES_PER_BEAT) ? CRCC_BYTES_PER_BEAT : int'(cnt);
    for (int i = 0; i < n; i++) begin
      crc = crc ^ {24'h0, bytes[8*i +: 8]};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRCC_POLY_REFL) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %08h, want %08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [63:0] lo, input logic [63:0] hi,
                         input logic [4:0] cnt, input logic first,
                         input logic last, input logic known,
                         input logic [31:0] sum);
    beat_t b;
    b.lo = lo; b.hi = hi; b.cnt = cnt; b.first = first; b.last = last;
    b.known = known; b.sum = sum;
    directed_q.push_back(b);
  endtask

  task automatic predict_beat(input beat_t b);
    logic [31:0] crc;
    crc = crc_fold_beat(b.first ? CRCC_ALL_ONES : crc_state, b.lo, b.hi, b.cnt);
    if (b.last) begin
      checksum_q.push_back(b.known ? b.sum : (crc ^ CRCC_ALL_ONES));
      crc_state = CRCC_ALL_ONES;
    end else begin
      crc_state = crc;
    end
  endtask

  task automatic send_beat(input beat_t b, input bit last_item);
    int gap;
    in_valid   <= 1'b1;
    data_low   <= b.lo;
    data_high  <= b.hi;
    byte_count <= b.cnt;
    first_beat <= b.first;
    last_beat  <= b.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b);
    beat_count++;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(13, 1) : 0;
    if (last_item || gap != 0) begin
      in_valid <= 1'b0;
    end
    repeat (gap) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 5'd0;
    if (r < 10) return 5'($urandom_range(31, 17));
    if (r < 40) return 5'd16;
    return 5'($urandom_range(16, 1));
  endfunction

  function automatic beat_t random_beat(input logic first, input logic last);
    beat_t b;
    b.lo = {$urandom, $urandom};
    b.hi = {$urandom, $urandom};
    b.cnt = pick_count();
    b.first = first;
    b.last = last;
    b.known = 1'b0;
    b.sum = '0;
    return b;
  endfunction

  initial begin
    int    total;
    int    beats;
    beat_t b;
    // "123456789" and the iSCSI 32-byte vectors
    add_row(64'h3837_3635_3433_3231, 64'h39, 5'd9, 1'b0, 1'b1, 1'b1, 32'he306_9283);
    add_row(64'h3837_3635_3433_3231, 64'h39, 5'd9, 1'b1, 1'b1, 1'b1, 32'he306_9283);
    add_row('1, '1, 5'd0, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
    add_row('0, '0, 5'd16, 1'b1, 1'b0, 1'b0, '0);
    add_row('0, '0, 5'd16, 1'b0, 1'b1, 1'b1, 32'h8a91_36aa);
    add_row('1, '1, 5'd16, 1'b1, 1'b0, 1'b0, '0);
    add_row('1, '1, 5'd16, 1'b0, 1'b1, 1'b1, 32'h62a8_ab43);
    add_row(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908, 5'd16, 1'b1, 1'b0,
            1'b0, '0);
    add_row(64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918, 5'd16, 1'b0, 1'b1,
            1'b1, 32'h46dd_794e);
    add_row(64'h3837_3635_3433_3231, 64'h39, 5'd9, 1'b0, 1'b1, 1'b1, 32'he306_9283);
    add_row('1, '1, 5'd31, 1'b1, 1'b1, 1'b0, '0);
    add_row(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd17, 1'b1, 1'b0,
            1'b0, '0);
    add_row('1, '1, 5'd0, 1'b0, 1'b0, 1'b0, '0);
    add_row(64'h5a, '0, 5'd1, 1'b0, 1'b0, 1'b0, '0);
    add_row(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd8, 1'b1, 1'b0,
            1'b0, '0);
    add_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd16, 1'b0, 1'b1,
            1'b0, '0);
    add_row('1, '0, 5'd15, 1'b1, 1'b0, 1'b0, '0);
    add_row('0, '1, 5'd0, 1'b0, 1'b1, 1'b0, '0);
    add_row('0, '0, 5'd1, 1'b1, 1'b1, 1'b0, '0);
    add_row('1, '1, 5'd1, 1'b1, 1'b1, 1'b0, '0);
    add_row(64'hdead_beef_cafe_f00d, 64'h8000_0000_0000_0001, 5'd16, 1'b1, 1'b1,
            1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_beat(directed_q[i], 1'b0);

    total = 700;
    while (beat_count < total) begin
      quiet = (beat_count >= total - 80);
      if ($urandom_range(9) == 0) begin
        b = random_beat(1'($urandom), 1'($urandom));
        send_beat(b, beat_count + 1 >= total);
      end else begin
        beats = $urandom_range(5, 1);
        for (int j = 0; j < beats; j++) begin
          b = random_beat(j == 0, j == beats - 1);
          send_beat(b, (j == beats - 1) && (beat_count + 1 >= total));
        end
      end
    end

    while (checksum_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d beats and checked %0d checksums, covering empty, saturated,",
             beat_count, sum_count);
    $display("restarted and multi-beat messages under random stalls on both sides.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int run;
    while (1) begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run = ($urandom_range(7) == 0) ? $urandom_range(120, 40) : $urandom_range(20, 1);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(13, 1)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (checksum_q.size() == 0) begin
        report_mismatch("checksum with none pending", checksum, '0);
      end else begin
        want_sum = checksum_q.pop_front();
        if (checksum !== want_sum) begin
          report_mismatch("checksum", checksum, want_sum);
        end
        sum_count++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d checksums pending", checksum_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
